// ===== rtl/core/assert_macros.svh =====
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_AT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition");
`else
`define ASSERT_AT(lbl, prop)
`define ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== rtl/core/lsc_pkg.sv =====
package lsc_pkg;

    localparam int CW = 12;
    localparam int SW = 4 * CW;
    localparam int LW = 2 * CW + 1;
    localparam int PW = 4 * CW + 26;

    localparam int ANGLE_W = 24;
    localparam int PERP_W  = 13;
    localparam int ALONG_W = 16;
    localparam int MINL_W  = 13;

    localparam logic [1:0] REG_ANGLE = 2'd0;
    localparam logic [1:0] REG_PERP  = 2'd1;
    localparam logic [1:0] REG_ALONG = 2'd2;
    localparam logic [1:0] REG_MINL  = 2'd3;

    localparam logic [ANGLE_W-1:0] ANGLE_RST = 24'd127442;
    localparam logic [PERP_W-1:0]  PERP_RST  = 13'd150;
    localparam logic [ALONG_W-1:0] ALONG_RST = 16'd2000;
    localparam logic [MINL_W-1:0]  MINL_RST  = 13'd50;

    typedef struct packed {
        logic [CW-1:0] x_start;
        logic [CW-1:0] y_start;
        logic [CW-1:0] x_end;
        logic [CW-1:0] y_end;
        logic          final_segment;
    } seg_t;

    typedef struct packed {
        logic [CW-1:0] rep_x_start;
        logic [CW-1:0] rep_y_start;
        logic [CW-1:0] rep_x_end;
        logic [CW-1:0] rep_y_end;
        logic          none_found;
        logic          last_result;
    } res_t;

    typedef struct packed {
        logic [CW-1:0] xs;
        logic [CW-1:0] ys;
        logic [CW-1:0] xe;
        logic [CW-1:0] ye;
    } coord_t;

endpackage

// ===== rtl/core/line_segment_clusterer.sv =====
// Line segment clusterer. Segments load one per cycle while busy is low; a word
// with final_segment set starts the clustering pass and holds busy high until
// the last result goes out. Each pair test runs up to thirteen products on one
// shared shift-add multiplier that retires one bit of the second operand per
// cycle; a pair test ends early when a test fails, an entry that is already
// taken is skipped where it is scanned, and a full set of n segments takes
// up to about n * (n - 1) / 2 pair tests. Results come out as single-cycle
// strobes on result_valid and cannot be held off; the receiver must take
// each one.
`include "assert_macros.svh"

module line_segment_clusterer
    import lsc_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  seg_t        segment,
    output logic        result_valid,
    output res_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CNW = IW + 1;
    localparam int MSW = 2 * CW + 4;

    localparam logic [3:0] S_LOAD       = 4'd0;
    localparam logic [3:0] S_SEED_SCAN  = 4'd1;
    localparam logic [3:0] S_SEED_FETCH = 4'd2;
    localparam logic [3:0] S_ISSUE      = 4'd3;
    localparam logic [3:0] S_RUN        = 4'd4;
    localparam logic [3:0] S_CAND_SCAN  = 4'd5;
    localparam logic [3:0] S_CAND_FETCH = 4'd6;
    localparam logic [3:0] S_CLOSE      = 4'd7;
    localparam logic [3:0] S_FINISH     = 4'd8;

    localparam logic [4:0] ST_SEED_FIRST = 5'd0;
    localparam logic [4:0] ST_SEED_LAST  = 5'd6;
    localparam logic [4:0] ST_CAND_FIRST = 5'd7;

    function automatic logic [PW-1:0] mag(input logic signed [PW:0] v);
        logic signed [PW:0] n;
        n = -v;
        return v[PW] ? n[PW-1:0] : v[PW-1:0];
    endfunction

    // configuration
    logic [ANGLE_W-1:0] angle_reg;
    logic [PERP_W-1:0]  perp_reg;
    logic [ALONG_W-1:0] along_reg;
    logic [MINL_W-1:0]  minl_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= ANGLE_RST;
            perp_reg  <= PERP_RST;
            along_reg <= ALONG_RST;
            minl_reg  <= MINL_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ANGLE: angle_reg <= pwdata[ANGLE_W-1:0];
                REG_PERP:  perp_reg  <= pwdata[PERP_W-1:0];
                REG_ALONG: along_reg <= pwdata[ALONG_W-1:0];
                REG_MINL:  minl_reg  <= pwdata[MINL_W-1:0];
                default:   angle_reg <= angle_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ANGLE: prdata = 32'(angle_reg);
            REG_PERP:  prdata = 32'(perp_reg);
            REG_ALONG: prdata = 32'(along_reg);
            REG_MINL:  prdata = 32'(minl_reg);
            default:   prdata = '0;
        endcase
    end

    // state
    logic [3:0]              state_reg, state_next;
    logic [4:0]              step_reg, step_next;
    logic [CNW-1:0]          count_reg, count_next;
    logic [CNW-1:0]          seed_reg, seed_next;
    logic [CNW-1:0]          cand_reg, cand_next;
    coord_t                  p_reg, p_next;
    coord_t                  best_reg, best_next;
    logic [LW-1:0]           best_len_reg, best_len_next;
    coord_t                  pend_reg, pend_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic [LW-1:0]           l1_reg, l1_next;
    logic [LW-1:0]           l2_reg, l2_next;
    logic signed [PW:0]      tmp_reg, tmp_next;
    logic [MSW-1:0]          magv_reg, magv_next;
    logic [PW-1:0]           lhs_reg, lhs_next;
    logic [PW-1:0]           perp_rhs_reg, perp_rhs_next;
    logic [PW-1:0]           along_rhs_reg, along_rhs_next;
    logic [2*MINL_W-1:0]     minsq_reg, minsq_next;
    logic                    result_valid_reg, result_valid_next;
    res_t                    result_reg, result_next;

    // shared multiplier
    logic [PW-1:0]      mul_a_reg, mul_a_next;
    logic [PW-1:0]      mul_b_reg, mul_b_next;
    logic [PW-1:0]      mul_acc_reg, mul_acc_next;
    logic               mul_neg_reg, mul_neg_next;
    logic signed [PW:0] mul_res;
    logic [PW-1:0]      mul_res_u;
    logic               mul_done;

    // segment memory
    coord_t        seg_mem [MAX_SEGMENTS];
    coord_t        rd_data_reg;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;

    // taken flags, cleared per entry as segments load
    logic          taken_mem [MAX_SEGMENTS];
    logic          taken_rd_reg;
    logic          tk_wr_en;
    logic [IW-1:0] tk_wr_addr;
    logic          tk_wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seg_mem[count_reg[IW-1:0]] <= '{segment.x_start, segment.y_start,
                                            segment.x_end, segment.y_end};
        end
        if (rd_en)
        begin
            rd_data_reg <= seg_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tk_wr_en)
        begin
            taken_mem[tk_wr_addr] <= tk_wr_data;
        end
        if (rd_en)
        begin
            taken_rd_reg <= taken_mem[rd_addr];
        end
    end

    // geometry of the seed (p) and candidate (q)
    coord_t                 q;
    logic signed [CW:0]     d1x, d1y, d2x, d2y;
    logic [CW:0]            qx2, qy2, px2, py2;
    logic signed [CW+1:0]   ex, ey, fx, fy;
    logic signed [PW:0]     opa, opb;
    logic signed [PW:0]     sum_res, dif_res;

    assign q   = rd_data_reg;
    assign d1x = signed'({1'b0, p_reg.xe}) - signed'({1'b0, p_reg.xs});
    assign d1y = signed'({1'b0, p_reg.ye}) - signed'({1'b0, p_reg.ys});
    assign d2x = signed'({1'b0, q.xe}) - signed'({1'b0, q.xs});
    assign d2y = signed'({1'b0, q.ye}) - signed'({1'b0, q.ys});
    assign qx2 = {1'b0, q.xs} + {1'b0, q.xe};
    assign qy2 = {1'b0, q.ys} + {1'b0, q.ye};
    assign px2 = {1'b0, p_reg.xs} + {1'b0, p_reg.xe};
    assign py2 = {1'b0, p_reg.ys} + {1'b0, p_reg.ye};
    assign ex  = signed'({1'b0, qx2}) - signed'({1'b0, p_reg.xs, 1'b0});
    assign ey  = signed'({1'b0, qy2}) - signed'({1'b0, p_reg.ys, 1'b0});
    assign fx  = signed'({1'b0, qx2}) - signed'({1'b0, px2});
    assign fy  = signed'({1'b0, qy2}) - signed'({1'b0, py2});

    assign mul_done  = (mul_b_reg == '0);
    assign mul_res   = mul_neg_reg ? -signed'({1'b0, mul_acc_reg})
                                   : signed'({1'b0, mul_acc_reg});
    assign mul_res_u = mul_res[PW-1:0];
    assign sum_res   = tmp_reg + mul_res;
    assign dif_res   = tmp_reg - mul_res;

    // operand decoder per step
    always_comb
    begin
        unique case (step_reg)
            5'd0:    begin opa = (PW+1)'(d1x);       opb = (PW+1)'(d1x);       end
            5'd1:    begin opa = (PW+1)'(d1y);       opb = (PW+1)'(d1y);       end
            5'd2:    begin opa = (PW+1)'(perp_reg);  opb = (PW+1)'(perp_reg);  end
            5'd3:    begin opa = tmp_reg;            opb = (PW+1)'(l1_reg);    end
            5'd4:    begin opa = (PW+1)'(along_reg); opb = (PW+1)'(along_reg); end
            5'd5:    begin opa = tmp_reg;            opb = (PW+1)'(l1_reg);    end
            5'd6:    begin opa = (PW+1)'(minl_reg);  opb = (PW+1)'(minl_reg);  end
            5'd7:    begin opa = (PW+1)'(d2x);       opb = (PW+1)'(d2x);       end
            5'd8:    begin opa = (PW+1)'(d2y);       opb = (PW+1)'(d2y);       end
            5'd9:    begin opa = (PW+1)'(d1x);       opb = (PW+1)'(d2y);       end
            5'd10:   begin opa = (PW+1)'(d1y);       opb = (PW+1)'(d2x);       end
            5'd11:   begin opa = (PW+1)'(magv_reg);  opb = (PW+1)'(magv_reg);  end
            5'd12:   begin opa = (PW+1)'(l1_reg);    opb = (PW+1)'(l2_reg);    end
            5'd13:   begin opa = tmp_reg;            opb = (PW+1)'(angle_reg); end
            5'd14:   begin opa = (PW+1)'(ex);        opb = (PW+1)'(d1y);       end
            5'd15:   begin opa = (PW+1)'(ey);        opb = (PW+1)'(d1x);       end
            5'd16:   begin opa = (PW+1)'(magv_reg);  opb = (PW+1)'(magv_reg);  end
            5'd17:   begin opa = (PW+1)'(d1x);       opb = (PW+1)'(fx);        end
            5'd18:   begin opa = (PW+1)'(d1y);       opb = (PW+1)'(fy);        end
            5'd19:   begin opa = (PW+1)'(magv_reg);  opb = (PW+1)'(magv_reg);  end
            default: begin opa = '0;                 opb = '0;                 end
        endcase
    end

    assign busy = (state_reg != S_LOAD);

    always_comb
    begin
        logic pass;
        logic fail;
        logic seg_done;
        pass             = 1'b0;
        fail             = 1'b0;
        seg_done         = 1'b0;
        state_next       = state_reg;
        step_next        = step_reg;
        count_next       = count_reg;
        seed_next        = seed_reg;
        cand_next        = cand_reg;
        p_next           = p_reg;
        best_next        = best_reg;
        best_len_next    = best_len_reg;
        pend_next        = pend_reg;
        pend_valid_next  = pend_valid_reg;
        l1_next          = l1_reg;
        l2_next          = l2_reg;
        tmp_next         = tmp_reg;
        magv_next        = magv_reg;
        lhs_next         = lhs_reg;
        perp_rhs_next    = perp_rhs_reg;
        along_rhs_next   = along_rhs_reg;
        minsq_next       = minsq_reg;
        result_valid_next = 1'b0;
        result_next      = result_reg;
        mul_a_next       = {mul_a_reg[PW-2:0], 1'b0};
        mul_b_next       = {1'b0, mul_b_reg[PW-1:1]};
        mul_acc_next     = mul_b_reg[0] ? mul_acc_reg + mul_a_reg : mul_acc_reg;
        mul_neg_next     = mul_neg_reg;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        tk_wr_en         = 1'b0;
        tk_wr_addr       = '0;
        tk_wr_data       = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (start)
                begin
                    if (count_reg < CNW'(MAX_SEGMENTS))
                    begin
                        wr_en      = 1'b1;
                        tk_wr_en   = 1'b1;
                        tk_wr_addr = count_reg[IW-1:0];
                        tk_wr_data = 1'b0;
                        count_next = count_reg + 1'b1;
                    end
                    if (segment.final_segment)
                    begin
                        seed_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_SEED_SCAN;
                    end
                end
            end
            S_SEED_SCAN:
            begin
                if (seed_reg >= count_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = seed_reg[IW-1:0];
                    state_next = S_SEED_FETCH;
                end
            end
            S_SEED_FETCH:
            begin
                if (taken_rd_reg)
                begin
                    seed_next  = seed_reg + 1'b1;
                    state_next = S_SEED_SCAN;
                end
                else
                begin
                    p_next     = rd_data_reg;
                    step_next  = ST_SEED_FIRST;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                mul_a_next   = mag(opa);
                mul_b_next   = mag(opb);
                mul_acc_next = '0;
                mul_neg_next = opa[PW] ^ opb[PW];
                state_next   = S_RUN;
            end
            S_RUN:
            begin
                if (mul_done)
                begin
                    seg_done = 1'b1;
                    case (step_reg)
                        5'd1:  l1_next = sum_res[LW-1:0];
                        5'd3:  perp_rhs_next = {mul_res_u[PW-3:0], 2'b00};
                        5'd5:  along_rhs_next = {mul_res_u[PW-3:0], 2'b00};
                        5'd6:  minsq_next = mul_res_u[2*MINL_W-1:0];
                        5'd8:  l2_next = sum_res[LW-1:0];
                        5'd10: magv_next = MSW'(mag(dif_res));
                        5'd11: lhs_next = {mul_res_u[PW-25:0], 24'd0};
                        5'd13: fail = !(lhs_reg < mul_res_u);
                        5'd15: magv_next = MSW'(mag(dif_res));
                        5'd16: fail = (perp_rhs_reg < mul_res_u);
                        5'd18: magv_next = MSW'(mag(sum_res));
                        5'd19:
                        begin
                            pass = (mul_res_u < along_rhs_reg);
                            fail = !pass;
                        end
                        default: tmp_next = mul_res;
                    endcase
                    if (step_reg == ST_SEED_LAST)
                    begin
                        best_len_next = l1_reg;
                        best_next     = p_reg;
                        if (l1_reg == '0)
                        begin
                            state_next = S_CLOSE;
                        end
                        else
                        begin
                            cand_next  = seed_reg + 1'b1;
                            state_next = S_CAND_SCAN;
                        end
                    end
                    else if (pass)
                    begin
                        tk_wr_en   = 1'b1;
                        tk_wr_addr = cand_reg[IW-1:0];
                        tk_wr_data = 1'b1;
                        if (l2_reg > best_len_reg)
                        begin
                            best_len_next = l2_reg;
                            best_next     = q;
                        end
                        cand_next  = cand_reg + 1'b1;
                        state_next = S_CAND_SCAN;
                    end
                    else if (fail)
                    begin
                        cand_next  = cand_reg + 1'b1;
                        state_next = S_CAND_SCAN;
                    end
                    else
                    begin
                        step_next  = step_reg + 1'b1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_CAND_SCAN:
            begin
                if (cand_reg >= count_reg)
                begin
                    state_next = S_CLOSE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cand_reg[IW-1:0];
                    state_next = S_CAND_FETCH;
                end
            end
            S_CAND_FETCH:
            begin
                if (taken_rd_reg)
                begin
                    cand_next  = cand_reg + 1'b1;
                    state_next = S_CAND_SCAN;
                end
                else
                begin
                    step_next  = ST_CAND_FIRST;
                    state_next = S_ISSUE;
                end
            end
            S_CLOSE:
            begin
                // hold one qualifying word back so the last one can be marked
                if (minsq_reg <= (2*MINL_W)'(best_len_reg))
                begin
                    if (pend_valid_reg)
                    begin
                        result_valid_next = 1'b1;
                        result_next = '{pend_reg.xs, pend_reg.ys, pend_reg.xe,
                                        pend_reg.ye, 1'b0, 1'b0};
                    end
                    pend_next       = best_reg;
                    pend_valid_next = 1'b1;
                end
                seed_next  = seed_reg + 1'b1;
                state_next = S_SEED_SCAN;
            end
            S_FINISH:
            begin
                result_valid_next = 1'b1;
                if (pend_valid_reg)
                begin
                    result_next = '{pend_reg.xs, pend_reg.ys, pend_reg.xe,
                                    pend_reg.ye, 1'b0, 1'b1};
                end
                else
                begin
                    result_next = '{'0, '0, '0, '0, 1'b1, 1'b1};
                end
                pend_valid_next = 1'b0;
                count_next      = '0;
                seed_next       = '0;
                state_next      = S_LOAD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
        if (seg_done && !mul_done)
        begin
            state_next = S_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            step_reg         <= '0;
            count_reg        <= '0;
            seed_reg         <= '0;
            cand_reg         <= '0;
            best_len_reg     <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            mul_b_reg        <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            count_reg        <= count_next;
            seed_reg         <= seed_next;
            cand_reg         <= cand_next;
            best_len_reg     <= best_len_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
            mul_b_reg        <= mul_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        best_reg      <= best_next;
        pend_reg      <= pend_next;
        l1_reg        <= l1_next;
        l2_reg        <= l2_next;
        tmp_reg       <= tmp_next;
        magv_reg      <= magv_next;
        lhs_reg       <= lhs_next;
        perp_rhs_reg  <= perp_rhs_next;
        along_rhs_reg <= along_rhs_next;
        minsq_reg     <= minsq_next;
        result_reg    <= result_next;
        mul_a_reg     <= mul_a_next;
        mul_acc_reg   <= mul_acc_next;
        mul_neg_reg   <= mul_neg_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_AT(a_none_is_last, result_valid && result.none_found |-> result.last_result)
    `ASSERT_AT(a_last_frees_block, result_valid && result.last_result |-> !busy)
    `ASSERT_NEVER(a_count_bound, count_reg > CNW'(MAX_SEGMENTS))
    `ASSERT_AT(a_idle_no_pending, !busy |-> !pend_valid_reg)

endmodule
